// ----- design/wpv_pkg.sv -----
// ----------------------------------------------------------------------------
// wpv_pkg: shared types and codes for the path validator
// Config register map, config bundle, result record and status codes.
// ----------------------------------------------------------------------------
package wpv_pkg;

  // config port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_MINUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_TILDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_SPACE  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic mode;
    logic allow_minus;
    logic allow_tilde;
    logic allow_period;
    logic allow_space;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] stop_index;
    logic [7:0] split_index;
    logic       split_found;
  } result_t;

endpackage

// ----- design/wpv_char_if.sv -----
// ----------------------------------------------------------------------------
// wpv_char_if: character stream channel
// One character per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wpv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// ----- design/wpv_result_if.sv -----
// ----------------------------------------------------------------------------
// wpv_result_if: validation result channel
// One result per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wpv_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] stop_index;
  logic [7:0] split_index;
  logic       split_found;

  modport source (output valid, output status, output stop_index,
                  output split_index, output split_found, input ready);
  modport sink   (input valid, input status, input stop_index,
                  input split_index, input split_found, output ready);
endinterface

// ----- design/wpv_cfg.sv -----
// ----------------------------------------------------------------------------
// wpv_cfg: configuration register file
// Five single-bit option registers behind a plain write port.
// ----------------------------------------------------------------------------
module wpv_cfg
  import wpv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  addr,
  input  logic [CFG_DATA_W-1:0] wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= 1'b0;
      cfg.allow_minus  <= 1'b1;
      cfg.allow_tilde  <= 1'b1;
      cfg.allow_period <= 1'b0;
      cfg.allow_space  <= 1'b0;
    end else if (wr_en) begin
      case (addr)
        CFG_MODE:         cfg.mode         <= wdata[0];
        CFG_ALLOW_MINUS:  cfg.allow_minus  <= wdata[0];
        CFG_ALLOW_TILDE:  cfg.allow_tilde  <= wdata[0];
        CFG_ALLOW_PERIOD: cfg.allow_period <= wdata[0];
        CFG_ALLOW_SPACE:  cfg.allow_space  <= wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/wpv_parse.sv -----
// ----------------------------------------------------------------------------
// wpv_parse: per-character grammar state machine
// Advances the parse state by one character per step and forms the result
// that a terminator releases.
// ----------------------------------------------------------------------------
module wpv_parse
  import wpv_pkg::*;
#(
  parameter int MAX_LEN = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  input  cfg_t       cfg,
  output result_t    result
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_BSL      = 8'h5C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_USCORE   = 8'h5F;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef enum logic [3:0] {
    S_START, S_B1, S_SRV0, S_SRV, S_DEV, S_D1, S_P2, S_PB, S_PBD,
    S_RS, S_LDOT, S_SUB, S_SPC, S_DOT
  } state_t;

  typedef enum logic [1:0] {CTX_ROOT, CTX_TOP, CTX_FILE} ctx_t;

  // sub-component tracker: saturating length, first three chars, 4th digit
  typedef struct packed {
    logic [2:0]      len;
    logic [2:0][7:0] prefix;
    logic            fd;
  } sub_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_lead(logic [7:0] c);
    return is_alpha(c) || is_num(c) || c == CH_USCORE;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - CASE_OFFSET : c;
  endfunction

  function automatic sub_t add_char(sub_t s, logic [7:0] c);
    sub_t r;
    r = s;
    if (s.len < 3'd3) r.prefix[s.len[1:0]] = to_upper(c);
    if (s.len == 3'd3) r.fd = is_num(c);
    if (s.len < 3'd5) r.len = s.len + 3'd1;
    return r;
  endfunction

  function automatic logic reserved(sub_t s);
    logic [7:0] a, b, d;
    a = s.prefix[0];
    b = s.prefix[1];
    d = s.prefix[2];
    if (s.len == 3'd3)
      return (a == "A" && b == "U" && d == "X") || (a == "C" && b == "O" && d == "N") ||
             (a == "N" && b == "U" && d == "L") || (a == "P" && b == "R" && d == "N");
    if (s.len == 3'd4 && s.fd)
      return (a == "C" && b == "O" && d == "M") || (a == "L" && b == "P" && d == "T");
    return 1'b0;
  endfunction

  state_t        state, state_next;
  ctx_t          ctx, ctx_next;
  logic [CW-1:0] char_index, char_index_next;
  sub_t          sub, sub_next;
  logic          dot_used, dot_used_next;
  logic          err, err_next;
  logic [1:0]    err_code, err_code_next;
  logic [7:0]    err_index, err_index_next;
  logic [7:0]    split_pos, split_pos_next;
  logic          split_seen, split_seen_next;

  logic [XW-1:0] ix;
  logic [7:0]    i8;
  logic          term, at_limit, comp;

  assign ix       = XW'(char_index);
  assign i8       = ix[7:0];
  assign term     = (ch == CH_NUL);
  assign at_limit = (char_index >= CW'(MAX_LEN));
  assign comp     = is_lead(ch) || (cfg.allow_minus && ch == CH_MINUS) ||
                    (cfg.allow_tilde && ch == CH_TILDE);

  always_comb begin
    state_t     es;
    logic       fail;
    logic [7:0] fail_at;

    state_next      = state;
    ctx_next        = ctx;
    sub_next        = sub;
    dot_used_next   = dot_used;
    err_next        = err;
    err_code_next   = err_code;
    err_index_next  = err_index;
    split_pos_next  = split_pos;
    split_seen_next = split_seen;
    fail            = 1'b0;
    fail_at         = i8;
    es              = state;

    if (!err && !term && at_limit) begin
      err_next       = 1'b1;
      err_code_next  = ST_TOO_LONG;
      err_index_next = 8'(MAX_LEN);
    end else if (!err) begin
      // lookahead states fall through to the root-path or period handling
      if ((state == S_B1 && ch != CH_BSL) || (state == S_PB && ch != CH_DOT))
        es = S_RS;
      if (state == S_PBD && ch != CH_DOT && cfg.allow_period) begin
        ctx_next        = CTX_ROOT;
        split_pos_next  = i8 - 8'd1;
        split_seen_next = 1'b1;
        dot_used_next   = 1'b0;
        es              = S_LDOT;
      end

      case (es)
        S_START: begin
          split_seen_next = 1'b0;
          dot_used_next   = 1'b0;
          if (cfg.mode) begin
            ctx_next = CTX_FILE;
            if (is_lead(ch)) begin
              sub_next   = add_char('{len: 3'd0, prefix: sub.prefix, fd: 1'b0}, ch);
              state_next = S_SUB;
            end else if (ch == CH_DOT && cfg.allow_period) begin
              state_next = S_LDOT;
            end else begin
              fail = 1'b1;
            end
          end else if (ch == CH_BSL) begin
            state_next = S_B1;
          end else if (ch == CH_DOT) begin
            state_next = S_D1;
          end else if (is_lead(ch)) begin
            ctx_next        = CTX_TOP;
            split_pos_next  = 8'd0;
            split_seen_next = 1'b1;
            sub_next        = add_char('{len: 3'd0, prefix: sub.prefix, fd: 1'b0}, ch);
            state_next      = S_SUB;
          end else begin
            fail = 1'b1;
          end
        end
        S_B1:   state_next = S_SRV0;
        S_SRV0: begin
          if (is_lead(ch)) state_next = S_SRV;
          else fail = 1'b1;
        end
        S_SRV: begin
          if (ch == CH_BSL) state_next = S_RS;
          else if (!is_lead(ch)) fail = 1'b1;
        end
        S_DEV: begin
          if (ch == CH_BSL) state_next = S_RS;
          else fail = 1'b1;
        end
        S_D1: begin
          if (!term) begin
            if (ch == CH_BSL) begin
              state_next = S_RS;
            end else if (ch == CH_DOT) begin
              state_next = S_P2;
            end else if (is_lead(ch) && cfg.allow_period) begin
              ctx_next        = CTX_TOP;
              split_pos_next  = 8'd0;
              split_seen_next = 1'b1;
              dot_used_next   = 1'b0;
              sub_next        = add_char('{len: 3'd0, prefix: sub.prefix, fd: 1'b0}, ch);
              state_next      = S_SUB;
            end else begin
              fail    = 1'b1;
              fail_at = 8'd0;
            end
          end
        end
        S_P2: begin
          if (ch == CH_BSL) state_next = S_PB;
          else if (!term) fail = 1'b1;
        end
        S_PB:   state_next = S_PBD;
        S_PBD: begin
          if (ch == CH_DOT) begin
            state_next = S_P2;
          end else begin
            fail    = 1'b1;
            fail_at = i8 - 8'd1;
          end
        end
        S_RS: begin
          if (!term) begin
            if (is_lead(ch)) begin
              ctx_next        = CTX_ROOT;
              split_pos_next  = i8;
              split_seen_next = 1'b1;
              dot_used_next   = 1'b0;
              sub_next        = add_char('{len: 3'd0, prefix: sub.prefix, fd: 1'b0}, ch);
              state_next      = S_SUB;
            end else if (ch == CH_DOT && cfg.allow_period) begin
              ctx_next        = CTX_ROOT;
              split_pos_next  = i8;
              split_seen_next = 1'b1;
              dot_used_next   = 1'b0;
              state_next      = S_LDOT;
            end else begin
              fail = 1'b1;
            end
          end
        end
        S_LDOT, S_DOT: begin
          if (is_lead(ch)) begin
            sub_next   = add_char('{len: 3'd0, prefix: sub.prefix, fd: 1'b0}, ch);
            state_next = S_SUB;
          end else begin
            fail = 1'b1;
          end
        end
        S_SUB: begin
          if (comp) begin
            sub_next = add_char(sub, ch);
          end else if (ch == CH_SPACE && cfg.allow_space) begin
            state_next = S_SPC;
          end else if (ctx == CTX_TOP && char_index == CW'(1) && ch == CH_COLON &&
                       is_alpha(sub.prefix[0])) begin
            // drive letter
            split_seen_next = 1'b0;
            state_next      = S_DEV;
          end else if (reserved(sub)) begin
            fail    = 1'b1;
            fail_at = i8 - 8'd1;
          end else if (!term) begin
            if (ch == CH_DOT) begin
              if (!dot_used || cfg.allow_period) begin
                dot_used_next = 1'b1;
                if (ctx == CTX_FILE) begin
                  split_pos_next  = i8;
                  split_seen_next = 1'b1;
                end
                state_next = S_DOT;
              end else begin
                fail = 1'b1;
              end
            end else if (ch == CH_BSL && ctx == CTX_ROOT) begin
              split_seen_next = 1'b0;
              state_next      = S_RS;
            end else begin
              fail = 1'b1;
            end
          end
        end
        S_SPC: begin
          if (comp) begin
            sub_next   = add_char(add_char(sub, CH_SPACE), ch);
            state_next = S_SUB;
          end else begin
            fail    = 1'b1;
            fail_at = reserved(sub) ? i8 - 8'd2 : i8 - 8'd1;
          end
        end
        default: fail = 1'b1;
      endcase

      if (fail) begin
        err_next       = 1'b1;
        err_code_next  = ST_INVALID;
        err_index_next = fail_at;
      end
    end

    if (term) char_index_next = '0;
    else if (!at_limit) char_index_next = char_index + CW'(1);
    else char_index_next = char_index;
  end

  // result released by a terminator
  always_comb begin
    if (err_next) begin
      result.status      = err_code_next;
      result.stop_index  = err_index_next;
      result.split_index = 8'd0;
      result.split_found = 1'b0;
    end else begin
      result.status      = ST_VALID;
      result.stop_index  = i8;
      result.split_index = split_seen_next ? split_pos_next : 8'd0;
      result.split_found = split_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_START;
      ctx        <= CTX_ROOT;
      char_index <= '0;
      sub.len    <= 3'd0;
      sub.fd     <= 1'b0;
      dot_used   <= 1'b0;
      err        <= 1'b0;
      split_seen <= 1'b0;
    end else if (step) begin
      char_index <= char_index_next;
      sub.prefix <= sub_next.prefix;
      if (term) begin
        state      <= S_START;
        ctx        <= CTX_ROOT;
        sub.len    <= 3'd0;
        sub.fd     <= 1'b0;
        dot_used   <= 1'b0;
        err        <= 1'b0;
        split_seen <= 1'b0;
      end else begin
        state      <= state_next;
        ctx        <= ctx_next;
        sub.len    <= sub_next.len;
        sub.fd     <= sub_next.fd;
        dot_used   <= dot_used_next;
        err        <= err_next;
        split_seen <= split_seen_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (step) begin
      err_code   <= err_code_next;
      err_index  <= err_index_next;
      split_pos  <= split_pos_next;
    end
  end

endmodule

// ----- design/windows_path_validator_unit.sv -----
// Latency: a terminator beat passes the input register, then the grammar step into the result register.
// Throughput: one character beat per cycle; result beats stall only the terminator.
// Rate is set by the grammar step between input and result registers.
// Reset (rst, synchronous, active high) clears the parse state, both stage valids
// and the option registers to their defaults (path mode, minus and tilde allowed).
// ----------------------------------------------------------------------------
// windows_path_validator_unit: streaming path / filename validator
// Checks a zero-terminated character stream against the pathname or filename
// grammar and emits one result beat per terminator.
// ----------------------------------------------------------------------------
module windows_path_validator_unit
  import wpv_pkg::*;
#(
  parameter int MAX_LEN = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wpv_char_if.sink              char_chan,
  wpv_result_if.source          result_chan
);

  cfg_t       cfg;

  // input stage: one character beat
  logic       in_valid;
  logic [7:0] in_ch;

  // output stage: one result beat
  logic       out_valid;
  result_t    out_data;

  result_t    res;
  logic       term;
  logic       step;

  // option registers
  wpv_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // A character moves into the parser unless it is a terminator and the
  // result register is still holding an untaken beat.
  assign term           = (in_ch == 8'd0);
  assign step           = in_valid && (!term || !out_valid || result_chan.ready);
  assign char_chan.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_chan.ready) begin
      in_valid <= char_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_chan.ready && char_chan.valid) in_ch <= char_chan.ch;
  end

  // grammar state machine
  wpv_parse #(
    .MAX_LEN (MAX_LEN)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .ch     (in_ch),
    .cfg    (cfg),
    .result (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && term) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && term) out_data <= res;
  end

  assign result_chan.valid       = out_valid;
  assign result_chan.status      = out_data.status;
  assign result_chan.stop_index  = out_data.stop_index;
  assign result_chan.split_index = out_data.split_index;
  assign result_chan.split_found = out_data.split_found;

  // a terminator that enters the parser always leaves a result beat behind
  a_term_gives_result: assert property (@(posedge clk) disable iff (rst)
    (step && term) |=> out_valid)
    else $error("terminator produced no result beat");

  // failed strings never report a split point
  a_error_no_split: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_VALID) |->
      (!out_data.split_found && out_data.split_index == 8'd0))
    else $error("error result carries a split point");

  // overlength strings stop at the length limit
  a_too_long_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_TOO_LONG) |->
      (out_data.stop_index == 8'(MAX_LEN)))
    else $error("too-long result with wrong stop index");

endmodule
